FILE: sv/htif_pkg.sv
// htif_pkg: shared types and codes for the tohost/fromhost device
`timescale 1ns / 1ps
package htif_pkg;

  // access kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ORDER         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_ON_READ       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_TERMINATE = 2'd2;

  // tohost command codes
  localparam logic [7:0] DEV_SYSCALL = 8'd0;
  localparam logic [7:0] DEV_CONSOLE = 8'd1;
  localparam logic [7:0] CMD_EXIT    = 8'd0;
  localparam logic [7:0] CMD_GETC    = 8'd0;
  localparam logic [7:0] CMD_PUTC    = 8'd1;

  // field layout of a tohost word
  localparam int DEV_LSB     = 56;
  localparam int CMD_LSB     = 48;
  localparam int PAYLOAD_W   = 48;
  localparam int READ_LENGTH = 8;

  typedef struct packed {
    logic swap_order;
    logic poll_on_read;
    logic suppress_terminate;
  } htif_cfg_t;

  typedef struct packed {
    logic        read_valid;
    logic [63:0] read_data;
    logic        char_out_valid;
    logic [7:0]  char_out;
    logic        pass;
    logic        fail;
    logic        terminate_req;
    logic        bad_command;
  } htif_result_t;

endpackage

FILE: sv/htif_tohost_fromhost_device.sv
// htif_tohost_fromhost_device: top level with fromhost word and result register
//
// Host-target interface device: a 16-byte window with a tohost and a
// fromhost doubleword. Requests enter on in_valid/in_ready with req_type,
// byte_offset, access_length, write_data and console_char. Every request
// gives exactly one result on out_valid/out_ready, carrying read data,
// an emitted console character and the pass/fail/terminate/bad_command
// flags. Misaligned requests and reads not 8 bytes long give an all-zero
// result.
// The result is registered: a request's result is shown from the cycle
// after it is accepted. Throughput is one request per cycle while out_ready
// is high; the decode is a single level of logic ahead of the result register.
// When the receiver stalls, the result holds and in_ready drops until the
// result is taken, so no result is lost.
// Reset clears the fromhost word, the configuration registers and the
// result valid. Configuration is written through cfg_we/cfg_index/cfg_data,
// and the user must do so only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
module htif_tohost_fromhost_device (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [htif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [3:0]                     byte_offset,
  input  logic [3:0]                     access_length,
  input  logic [63:0]                    write_data,
  input  logic [6:0]                     console_char,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           read_valid,
  output logic [63:0]                    read_data,
  output logic                           char_out_valid,
  output logic [7:0]                     char_out,
  output logic                           pass,
  output logic                           fail,
  output logic                           terminate_req,
  output logic                           bad_command
);
  import htif_pkg::*;

  htif_cfg_t    cfg;
  logic [63:0]  fromhost;
  htif_result_t result_next;
  htif_result_t result;
  logic         fromhost_we;
  logic [63:0]  fromhost_next;
  logic         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  htif_exec u_exec (
    .cfg           (cfg),
    .fromhost      (fromhost),
    .req_type      (req_type),
    .byte_offset   (byte_offset),
    .access_length (access_length),
    .write_data    (write_data),
    .console_char  (console_char),
    .result        (result_next),
    .fromhost_we   (fromhost_we),
    .fromhost_next (fromhost_next)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWAP_ORDER:         cfg.swap_order         <= cfg_data;
        CFG_POLL_ON_READ:       cfg.poll_on_read       <= cfg_data;
        CFG_SUPPRESS_TERMINATE: cfg.suppress_terminate <= cfg_data;
        default: ;
      endcase
    end
  end

  // fromhost word
  always_ff @(posedge clk) begin
    if (rst) begin
      fromhost <= '0;
    end else if (accept && fromhost_we) begin
      fromhost <= fromhost_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign read_valid     = result.read_valid;
  assign read_data      = result.read_data;
  assign char_out_valid = result.char_out_valid;
  assign char_out       = result.char_out;
  assign pass           = result.pass;
  assign fail           = result.fail;
  assign terminate_req  = result.terminate_req;
  assign bad_command    = result.bad_command;

endmodule

FILE: sv/htif_exec.sv
// htif_exec: decode of one request and the fromhost update it causes
`timescale 1ns / 1ps
module htif_exec (
  input  htif_pkg::htif_cfg_t    cfg,
  input  logic [63:0]            fromhost,
  input  logic                   req_type,
  input  logic [3:0]             byte_offset,
  input  logic [3:0]             access_length,
  input  logic [63:0]            write_data,
  input  logic [6:0]             console_char,
  output htif_pkg::htif_result_t result,
  output logic                   fromhost_we,
  output logic [63:0]            fromhost_next
);
  import htif_pkg::*;

  logic        aligned;
  logic        dword_one;
  logic        hit_fromhost;
  logic        char_present;
  logic [7:0]  dev;
  logic [7:0]  cmd;
  logic [PAYLOAD_W-1:0] payload;
  logic [63:0] poll_word;

  // address decode
  assign aligned      = (byte_offset[2:0] == 3'd0);
  assign dword_one    = byte_offset[3];
  assign hit_fromhost = dword_one ^ cfg.swap_order;
  assign char_present = (console_char != 7'd0);
  assign dev          = write_data[DEV_LSB +: 8];
  assign cmd          = write_data[CMD_LSB +: 8];
  assign payload      = write_data[PAYLOAD_W-1:0];
  assign poll_word    = char_present ? {8'h01, 49'd0, console_char} : 64'd0;

  // request handling
  always_comb begin
    result        = '0;
    fromhost_we   = 1'b0;
    fromhost_next = write_data;
    if (aligned) begin
      if (req_type == REQ_READ) begin
        if (access_length == 4'(READ_LENGTH)) begin
          result.read_valid = 1'b1;
          if (hit_fromhost) begin
            if (cfg.poll_on_read) begin
              fromhost_we       = 1'b1;
              fromhost_next     = poll_word;
              result.read_data  = poll_word;
            end else begin
              result.read_data  = fromhost;
            end
          end
        end
      end else if (hit_fromhost) begin
        fromhost_we = 1'b1;
      end else if (dev == DEV_CONSOLE && cmd == CMD_PUTC) begin
        if (payload[7:0] != 8'd0) begin
          result.char_out_valid = 1'b1;
          result.char_out       = payload[7:0];
        end
      end else if (dev == DEV_CONSOLE && cmd == CMD_GETC) begin
        if (!cfg.poll_on_read && char_present) begin
          fromhost_we   = 1'b1;
          fromhost_next = {57'd0, console_char};
        end
      end else if (dev == DEV_SYSCALL && cmd == CMD_EXIT) begin
        if (payload == PAYLOAD_W'(1)) begin
          result.pass          = 1'b1;
          result.terminate_req = !cfg.suppress_terminate;
        end else begin
          result.fail = 1'b1;
        end
      end else begin
        result.bad_command = 1'b1;
      end
    end
  end

endmodule

FILE: sv/htif_checker.sv
// htif_checker: port-level assertions for the tohost/fromhost device
`timescale 1ns / 1ps
module htif_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        read_valid,
  input logic [63:0] read_data,
  input logic        char_out_valid,
  input logic        pass,
  input logic        fail,
  input logic        terminate_req,
  input logic        bad_command
);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("stalled result changed");

  // no result valid right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // terminate only comes with pass
  a_term_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && terminate_req |-> pass)
    else $error("terminate without pass");

  // one kind of effect per request
  a_one_effect: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({read_valid, char_out_valid, pass, fail, bad_command}) <= 1)
    else $error("more than one effect in a result");

endmodule

bind htif_tohost_fromhost_device htif_checker u_htif_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .read_valid     (read_valid),
  .read_data      (read_data),
  .char_out_valid (char_out_valid),
  .pass           (pass),
  .fail           (fail),
  .terminate_req  (terminate_req),
  .bad_command    (bad_command)
);
